@@ rtl/core/sobel_pkg.sv @@
package sobel_pkg;
  localparam int MaxWidth = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW = 11;
  localparam int RowW = 12;
  localparam int CfgW = 12;
  localparam int AddrW = 11;
  localparam logic [CfgW-1:0] WidthReset = 12'd640;
  localparam logic [RowW-1:0] RowMax = RowW'(MaxHeight - 1);
endpackage

@@ rtl/core/sobel_ram.sv @@
module sobel_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/sobel_edge_magnitude.sv @@
// Pipeline from input request to result: RAM read and gray, window, gradient, sum of squares,
//   root load, 8-step square root, output register.
// Throughput: one pixel per cycle; a stalled output stalls the whole pipeline.
// Line stores are one-read/one-write RAMs; while stalled they re-read the held column.
//   Back-to-back pixels share a column only across a frame start on row zero.
// Reset (rst, synchronous) clears counters, window, valid bits and sets line_width to 640.
module sobel_edge_magnitude (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // blue, green, red
  input  logic        s_axis_tuser,  // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // edge_value, out_column, out_row, zero pad
);
  localparam int Sq = 8;

  logic [sobel_pkg::CfgW-1:0] line_width;
  logic [sobel_pkg::ColW-1:0] col;
  logic [sobel_pkg::RowW-1:0] row;
  logic adv;

  // stage 1 registers
  logic s1v, s1emit;
  logic [7:0] s1b, s1g, s1r;
  logic [sobel_pkg::AddrW-1:0] s1idx;
  logic [sobel_pkg::ColW-1:0] s1col;
  logic [sobel_pkg::RowW-1:0] s1row;
  logic [7:0] old_rd, new_rd;

  // stage 2
  logic s2v, s2emit;
  logic [7:0] w [9];
  logic [sobel_pkg::ColW-1:0] s2col;
  logic [sobel_pkg::RowW-1:0] s2row;

  // stage 3 gradients
  logic s3v;
  logic [10:0] ax, ay;
  logic [sobel_pkg::ColW-1:0] s3col;
  logic [sobel_pkg::RowW-1:0] s3row;

  // stage 4 sum, saturated to 0x10000
  logic s4v;
  logic [16:0] sum4;
  logic [21:0] sq_full;
  logic [sobel_pkg::ColW-1:0] s4col;
  logic [sobel_pkg::RowW-1:0] s4row;

  // sqrt stages
  logic        qv [Sq+1];
  logic [16:0] qrem [Sq+1];
  logic [7:0]  qres [Sq+1];
  logic        qsat [Sq+1];
  logic [sobel_pkg::ColW-1:0] qcol [Sq+1];
  logic [sobel_pkg::RowW-1:0] qrow [Sq+1];

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic [sobel_pkg::CfgW-1:0] eff_w;
  always_comb begin
    if (line_width < 12'd3) begin
      eff_w = 12'd3;
    end else if (line_width > 12'(sobel_pkg::MaxWidth)) begin
      eff_w = 12'(sobel_pkg::MaxWidth);
    end else begin
      eff_w = line_width;
    end
  end

  logic [sobel_pkg::ColW-1:0] c_cur;
  logic [sobel_pkg::RowW-1:0] r_cur;
  assign c_cur = s_axis_tuser ? '0 : col;
  assign r_cur = s_axis_tuser ? '0 : row;

  logic [sobel_pkg::AddrW-1:0] rd_idx;
  assign rd_idx = c_cur;

  logic [sobel_pkg::AddrW-1:0] ram_raddr;
  assign ram_raddr = adv ? rd_idx : s1idx;

  logic [7:0] gray1;
  logic [15:0] wsum;
  always_comb begin
    wsum  = 16'(16'd30 * s1r) + 16'(16'd59 * s1g) + 16'(16'd11 * s1b);
    gray1 = 8'((32'(wsum) * 32'd5243) >> 19);
  end

  logic wr_en;
  assign wr_en = s1v && adv;

  sobel_ram #(.Width(8), .Depth(sobel_pkg::MaxWidth)) u_older (
    .clk, .we(wr_en), .waddr(s1idx), .wdata(new_rd), .raddr(ram_raddr), .rdata(old_rd)
  );
  sobel_ram #(.Width(8), .Depth(sobel_pkg::MaxWidth)) u_newer (
    .clk, .we(wr_en), .waddr(s1idx), .wdata(gray1), .raddr(ram_raddr), .rdata(new_rd)
  );

  logic signed [11:0] gx, gy;
  always_comb begin
    gx = (12'(w[2]) + 12'({w[5], 1'b0}) + 12'(w[8]))
       - (12'(w[0]) + 12'({w[3], 1'b0}) + 12'(w[6]));
    gy = (12'(w[6]) + 12'({w[7], 1'b0}) + 12'(w[8]))
       - (12'(w[0]) + 12'({w[1], 1'b0}) + 12'(w[2]));
  end

  assign sq_full = 22'(ax) * 22'(ax) + 22'(ay) * 22'(ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= sobel_pkg::WidthReset;
      col <= '0;
      row <= '0;
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
      for (int i = 0; i <= Sq; i++) begin
        qv[i] <= 1'b0;
      end
      for (int i = 0; i < 9; i++) begin
        w[i] <= '0;
      end
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        line_width <= cfg_wdata;
      end
      if (adv) begin
        s1v <= in_acc;
        if (in_acc) begin
          s1b <= s_axis_tdata[7:0];
          s1g <= s_axis_tdata[15:8];
          s1r <= s_axis_tdata[23:16];
          s1idx <= rd_idx;
          s1col <= c_cur;
          s1row <= r_cur;
          s1emit <= (r_cur >= 12'd2) && (c_cur >= 11'd2);
          if (13'(c_cur) + 13'd1 >= 13'(eff_w)) begin
            col <= '0;
            row <= (r_cur < sobel_pkg::RowMax) ? r_cur + 1'b1 : r_cur;
          end else begin
            col <= c_cur + 1'b1;
            row <= r_cur;
          end
        end
        s2v <= s1v && s1emit;
        if (s1v) begin
          for (int k = 0; k < 3; k++) begin
            w[k*3]   <= w[k*3+1];
            w[k*3+1] <= w[k*3+2];
          end
          w[2] <= old_rd;
          w[5] <= new_rd;
          w[8] <= gray1;
          s2col <= s1col - 1'b1;
          s2row <= s1row - 1'b1;
        end
        s3v <= s2v;
        ax <= 11'(gx[11] ? -gx : gx);
        ay <= 11'(gy[11] ? -gy : gy);
        s3col <= s2col;
        s3row <= s2row;
        s4v <= s3v;
        sum4 <= (sq_full > 22'h00FFFF) ? 17'h10000 : 17'(sq_full);
        s4col <= s3col;
        s4row <= s3row;
        qv[0] <= s4v;
        qrem[0] <= sum4;
        qres[0] <= '0;
        qsat[0] <= sum4[16];
        qcol[0] <= s4col;
        qrow[0] <= s4row;
        for (int i = 0; i < Sq; i++) begin
          logic [7:0] trial;
          trial = qres[i] | 8'(8'd1 << (Sq - 1 - i));
          qv[i+1] <= qv[i];
          qsat[i+1] <= qsat[i];
          qcol[i+1] <= qcol[i];
          qrow[i+1] <= qrow[i];
          if (17'(16'(trial) * 16'(trial)) <= qrem[i]) begin
            qres[i+1] <= trial;
          end else begin
            qres[i+1] <= qres[i];
          end
          qrem[i+1] <= qrem[i];
        end
        m_axis_tvalid <= qv[Sq];
        m_axis_tdata <= {1'b0, qrow[Sq], qcol[Sq], qsat[Sq] ? 8'hFF : qres[Sq]};
      end
    end
  end
endmodule

@@ rtl/core/sobel_checker.sv @@
module sobel_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_col: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[18:8] != 11'd0)
    else $error("border column emitted");
  a_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[30:19] != 12'd0 && m_axis_tdata[31] == 1'b0)
    else $error("border row emitted");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
endmodule

bind sobel_edge_magnitude sobel_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

@@ sim/sobel_edge_magnitude_test.sv @@
`timescale 1ns / 100ps
module sobel_edge_magnitude_test;

  typedef struct {
    logic [7:0]                 mag;
    logic [sobel_pkg::ColW-1:0] col;
    logic [sobel_pkg::RowW-1:0] row;
  } edge_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  sobel_edge_magnitude u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("sobel_edge_magnitude: mismatch");
    $finish;
  end

  // model state
  logic [7:0]                 gray_old [sobel_pkg::MaxWidth];
  logic [7:0]                 gray_new [sobel_pkg::MaxWidth];
  logic [7:0]                 win [9];
  int                         col_cnt = 0;
  int                         row_cnt = 0;
  logic [sobel_pkg::CfgW-1:0] width_reg = sobel_pkg::WidthReset;
  edge_t                      pending_edges [$];

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  initial begin
    for (int i = 0; i < sobel_pkg::MaxWidth; i++) begin
      gray_old[i] = '0;
      gray_new[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic predict_edge(input logic [7:0] b, g, r, input logic fs);
    int w, c, rw, idx, gray, gx, gy, s, m, c1, r1;
    edge_t e;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > sobel_pkg::MaxWidth) w = sobel_pkg::MaxWidth;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    rw = row_cnt;
    idx = (c < sobel_pkg::MaxWidth) ? c : sobel_pkg::MaxWidth - 1;
    gray = (30 * int'(r) + 59 * int'(g) + 11 * int'(b)) / 100;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = gray_old[idx];
    win[5] = gray_new[idx];
    win[8] = gray[7:0];
    gray_old[idx] = gray_new[idx];
    gray_new[idx] = gray[7:0];
    if (rw >= 2 && c >= 2) begin
      gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
         - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
      gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
         - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
      s = gx * gx + gy * gy;
      m = 0;
      while (m < 255 && (m + 1) * (m + 1) <= s) m++;
      c1 = c - 1;
      r1 = rw - 1;
      e.mag = m[7:0];
      e.col = c1[sobel_pkg::ColW-1:0];
      e.row = r1[sobel_pkg::RowW-1:0];
      pending_edges.push_back(e);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      if (rw < sobel_pkg::MaxHeight - 1) row_cnt = rw + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    edge_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_edges.size() == 0) begin
        report("unexpected result, tdata", m_axis_tdata, 0);
      end else begin
        e = pending_edges.pop_front();
        if (m_axis_tdata[7:0] != e.mag) report("edge_value", m_axis_tdata[7:0], e.mag);
        if (m_axis_tdata[18:8] != e.col) report("out_column", m_axis_tdata[18:8], e.col);
        if (m_axis_tdata[30:19] != e.row) report("out_row", m_axis_tdata[30:19], e.row);
      end
    end
  end

  task automatic send_pixel(input logic [23:0] bgr, input logic fs);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bgr;
    s_axis_tuser <= fs;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    predict_edge(bgr[7:0], bgr[15:8], bgr[23:16], fs);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_width(input logic [11:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = v;
  endtask

  // mode 0: random, 1: channels at 0 or 255, 2: stripes of black and white
  function automatic logic [23:0] make_pixel(input int mode, input int c);
    logic [23:0] p;
    case (mode)
      0: p = 24'($urandom());
      1: p = {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
              {8{1'($urandom_range(1))}}};
      default: p = (c % 2) ? 24'hFFFFFF : 24'h000000;
    endcase
    return p;
  endfunction

  task automatic send_frame(input int rows, input int cols, input int mode, input int noise);
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        send_pixel(make_pixel(mode, x),
                   (x == 0 && y == 0) || ($urandom_range(99) < noise));
      end
    end
  endtask

  task automatic test_directed();
    write_width(12'd0);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_frame(0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_pixel(make_pixel(2, i), 1'b0);
    write_width(12'd1);
    send_frame(3, 3, 1, 0);
    write_width(12'd2);
    send_frame(3, 3, 0, 0);
  endtask

  task automatic test_width_change_mid_row();
    write_width(12'd8);
    send_frame(3, 8, 0, 0);
    for (int i = 0; i < 6; i++) send_pixel(make_pixel(0, i), 1'b0);
    write_width(12'd4);
    for (int i = 0; i < 12; i++) send_pixel(make_pixel(0, i), 1'b0);
  endtask

  task automatic test_no_frame_start();
    write_width(12'd5);
    send_frame(3, 5, 0, 0);
    for (int i = 0; i < 15; i++) send_pixel(make_pixel(1, i), 1'b0);
  endtask

  task automatic test_random();
    int phase_idle [4] = '{0, 79, 0, 26};
    int phase_stall [4] = '{0, 0, 79, 26};
    int sent;
    int w, rows;
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      sent = 0;
      while (sent < 120) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(64, 3) : $urandom_range(12, 3);
        rows = $urandom_range(6, 3);
        write_width(w[11:0]);
        send_frame(rows, w, $urandom_range(2), ($urandom_range(3) == 0) ? 3 : 0);
        sent += rows * w;
        if (p == 1 && sent >= 60 && sent < 60 + rows * w) drain();
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_width_change_mid_row();
    test_no_frame_start();
    test_random();
    drain();
    if (errors == 0) begin
      $display("sobel_edge_magnitude: match");
    end else begin
      $display("sobel_edge_magnitude: mismatch");
    end
    $finish;
  end
endmodule

@@ sobel_edge_magnitude.f @@
rtl/core/sobel_pkg.sv
rtl/core/sobel_ram.sv
rtl/core/sobel_edge_magnitude.sv
rtl/core/sobel_checker.sv
sim/sobel_edge_magnitude_test.sv
